[sv/htfc_pkg.sv]
// Package for the humidity/temperature frame checker.
// Holds reply kinds, conversion constants, the CRC-8 step function and the result struct.
// No dependencies.
`default_nettype none

package htfc_pkg;

  // Measurement kinds carried in the kind bit
  typedef enum logic {
    KIND_TEMP  = 1'b0,
    KIND_HUMID = 1'b1
  } kind_t;

  localparam int unsigned READING_W = 12;
  localparam int unsigned COUNT_W   = 4;

  // CRC-8, polynomial 0x31, init 0x00, MSB first, no final xor
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // Raw word that the sensor returns when the bus floats
  localparam logic [15:0] RAW_INVALID = 16'hffff;

  // Scaling: value = ((raw & mask) * coef >> 16) - offset
  localparam logic [15:0] TEMP_MASK    = 16'hfffc;
  localparam logic [15:0] HUMID_MASK   = 16'hfff0;
  localparam logic [10:0] TEMP_COEF    = 11'd1757;
  localparam logic [10:0] HUMID_COEF   = 11'd1250;
  localparam logic signed [READING_W-1:0] TEMP_OFFSET  = 12'sd468;
  localparam logic signed [READING_W-1:0] HUMID_OFFSET = 12'sd60;
  localparam logic signed [READING_W-1:0] FAIL_VALUE   = -12'sd999;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 4'd10;

  // Result of checking and scaling one reply
  typedef struct packed {
    logic                        ok;
    logic signed [READING_W-1:0] reading;
  } conv_res_t;

  // One byte through the CRC shift register
  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    c = crc_in ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/humidity_temp_frame_checker_unit.sv]
// Top level of the humidity/temperature frame checker.
// Uses htfc_pkg and htfc_convert.
//
// Channel | Dir | tdata                                     | tuser
// --------+-----+-------------------------------------------+---------------------------
// in_     | in  | [7:0] high, [15:8] low, [23:16] check     | [0] kind, [1] no_reply
// out_    | out | [11:0] reading, [12] sensor_reset_request | [0] reading_ok
// cfg_    | in  | cfg_wr_data = fail_limit (4 bits)         | -
//
// Two register stages: an input register and a result register, with the check, CRC and
// scaling between them. One request per cycle is accepted while the output is not stalled;
// a request goes from the input register into the result register, which drives out_tvalid.
// Failure counters update as a request moves into the result register. A stalled output
// holds the result while the input register takes one more request. Reset (rst_n low,
// synchronous) clears both valids, the counters and sets fail_limit to 10.
`default_nettype none

module humidity_temp_frame_checker_unit
  import htfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] high_byte, [15:8] low_byte, [23:16] check_byte
  input  wire logic [1:0]  in_tuser,   // [0] kind, [1] no_reply
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [11:0] reading, [12] sensor_reset_request, rest 0
  output logic [0:0]       out_tuser,  // [0] reading_ok
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_wr_data
);

  logic               s1_valid_r, s1_valid_nxt;
  logic [23:0]        s1_data_r;
  logic [1:0]         s1_user_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r;
  logic [READING_W-1:0] out_reading_r;
  logic               out_req_r;
  logic [COUNT_W-1:0] fail_limit_r;
  logic [COUNT_W-1:0] temp_cnt_r, temp_cnt_nxt;
  logic [COUNT_W-1:0] humid_cnt_r, humid_cnt_nxt;

  logic               adv;
  logic               in_acc;
  conv_res_t          res;
  logic [COUNT_W-1:0] cur_cnt;
  logic [COUNT_W:0]   inc_cnt;
  logic               req;
  logic [COUNT_W-1:0] new_cnt;

  // Handshake: result register drains, input register refills in the same cycle
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : ((out_valid_r && out_tready) ? 1'b0 : out_valid_r);

  // Check and scale the held request
  htfc_convert u_conv (
    .kind       (s1_user_r[0]),
    .no_reply   (s1_user_r[1]),
    .high_byte  (s1_data_r[7:0]),
    .low_byte   (s1_data_r[15:8]),
    .check_byte (s1_data_r[23:16]),
    .res        (res)
  );

  // Consecutive-failure counter for the kind of the held request
  always_comb begin
    cur_cnt = s1_user_r[0] ? humid_cnt_r : temp_cnt_r;
    inc_cnt = {1'b0, cur_cnt} + 5'd1;
    req     = !res.ok && (inc_cnt >= {1'b0, fail_limit_r});
    new_cnt = (res.ok || req) ? '0 : inc_cnt[COUNT_W-1:0];
    temp_cnt_nxt  = temp_cnt_r;
    humid_cnt_nxt = humid_cnt_r;
    if (adv) begin
      if (s1_user_r[0]) begin
        humid_cnt_nxt = new_cnt;
      end else begin
        temp_cnt_nxt = new_cnt;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      temp_cnt_r   <= '0;
      humid_cnt_r  <= '0;
      fail_limit_r <= LIMIT_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      temp_cnt_r  <= temp_cnt_nxt;
      humid_cnt_r <= humid_cnt_nxt;
      if (cfg_wr_en) begin
        fail_limit_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_tdata;
      s1_user_r <= in_tuser;
    end
    if (adv) begin
      out_ok_r      <= res.ok;
      out_reading_r <= res.reading;
      out_req_r     <= req;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_req_r, out_reading_r};
  assign out_tuser  = out_ok_r;

  // A held request never drops without moving on
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> s1_valid_r)
    else $error("input register lost a request");

  // A good reading never comes with a reset request
  a_ok_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tdata[12]))
    else $error("reset request on a good reading");

  // Failed reading carries the failure value
  a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[11:0] == FAIL_VALUE))
    else $error("failed reading without failure value");

  // Success or reset request clears the counter of that kind
  a_temp_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !s1_user_r[0] && (res.ok || req)) |=> (temp_cnt_r == '0))
    else $error("temperature failure count not cleared");

  a_humid_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_user_r[0] && (res.ok || req)) |=> (humid_cnt_r == '0))
    else $error("humidity failure count not cleared");

endmodule

`default_nettype wire

[sv/htfc_convert.sv]
// Reply checker and scaler: CRC-8 check, invalid-word check and fixed-point scaling.
// Combinational; uses htfc_pkg.
`default_nettype none

module htfc_convert
  import htfc_pkg::*;
(
  input  wire logic       kind,
  input  wire logic       no_reply,
  input  wire logic [7:0] high_byte,
  input  wire logic [7:0] low_byte,
  input  wire logic [7:0] check_byte,
  output conv_res_t       res
);

  logic [15:0] raw;
  logic [7:0]  crc;
  logic [15:0] masked;
  logic [10:0] coef;
  logic [26:0] prod;
  logic signed [READING_W-1:0] scaled;
  logic signed [READING_W-1:0] offset;

  // Check byte over both data bytes
  assign raw = {high_byte, low_byte};
  assign crc = crc_byte(crc_byte(CRC_INIT, high_byte), low_byte);

  // Select mask, coefficient and offset by kind
  always_comb begin
    unique case (kind_t'(kind))
      KIND_TEMP: begin
        masked = raw & TEMP_MASK;
        coef   = TEMP_COEF;
        offset = TEMP_OFFSET;
      end
      KIND_HUMID: begin
        masked = raw & HUMID_MASK;
        coef   = HUMID_COEF;
        offset = HUMID_OFFSET;
      end
      default: begin
        masked = raw & TEMP_MASK;
        coef   = TEMP_COEF;
        offset = TEMP_OFFSET;
      end
    endcase
  end

  // 16x11 multiply, keep integer part (max 1756 fits 11 bits)
  assign prod   = {11'd0, masked} * {16'd0, coef};
  assign scaled = $signed({1'b0, prod[26:16]}) - offset;

  always_comb begin
    res.ok      = !no_reply && (crc == check_byte) && (raw != RAW_INVALID);
    res.reading = res.ok ? scaled : FAIL_VALUE;
  end

endmodule

`default_nettype wire
